### sv/i2cme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_START   = 7'b0000010,
    PH_STOP    = 7'b0000100,
    PH_WR_LOW  = 7'b0001000,
    PH_WR_HIGH = 7'b0010000,
    PH_RD_LOW  = 7'b0100000,
    PH_RD_HIGH = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [3:0]  STOP_SCL_STEP     = 4'd0;
  localparam logic [3:0]  STOP_SDA_STEP     = 4'd1;
  localparam logic [3:0]  LAST_DATA_BIT     = 4'd7;
  localparam logic [3:0]  BYTE_BITS         = 4'd8;

endpackage
`default_nettype wire

### sv/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master engine stepped by one input beat per bus tick: start, stop,
// write byte and read byte, with a programmable SCL half period.
// ----------------------------------------------------------------------------
// output: the result beat of a tick is registered on m_tdata in the cycle after
// the input beat is accepted
// throughput: one beat per cycle while m_tready is high, set by the single
// state update between the input handshake and the output register
// reset: synchronous, clears the bus state to idle with SCL and SDA released
// and the half period to 50 ticks
module i2c_master_byte_engine #(
  parameter int DIVIDER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // cmd_valid, tx_byte[7:0], send_ack, sda_in, zero pad
  input  wire logic [1:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // scl_out, sda_out, ready_res, done_res, rx_byte[7:0],
                                      // nack, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int CW = ((DIVIDER_BITS > 16) ? DIVIDER_BITS : 16) + 1;

  logic        cmd_valid;
  logic [1:0]  action;
  logic [7:0]  tx_byte;
  logic        send_ack;
  logic        sda_in;

  assign cmd_valid = s_tdata[0];
  assign tx_byte   = s_tdata[8:1];
  assign send_ack  = s_tdata[9];
  assign sda_in    = s_tdata[10];
  assign action    = s_tuser;

  logic [15:0]             half_period;
  i2cme_pkg::phase_t       phase, phase_next;
  logic [3:0]              bit_count, bit_count_next;
  logic [DIVIDER_BITS-1:0] divider, divider_next;
  logic [7:0]              shift_reg, shift_reg_next;
  logic                    scl_level, scl_level_next;
  logic                    sda_level, sda_level_next;
  logic                    ack_sampled, ack_sampled_next;
  logic                    ack_to_send, ack_to_send_next;
  logic [7:0]              rx_hold, rx_hold_next;
  logic                    done;

  logic [CW-1:0] div_plus;
  logic [CW-1:0] half_ext;
  logic [CW-1:0] half_lim;
  logic [CW-1:0] eff_half;
  logic          seg_end;
  logic [3:0]    bc_inc;
  logic [7:0]    shift_wr;
  logic [7:0]    shift_rd;
  logic          beat;

  assign beat      = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign div_plus = CW'(divider) + CW'(1);
  assign half_ext = CW'(half_period);
  assign half_lim = CW'(1) << DIVIDER_BITS;
  assign eff_half = (half_period == 16'd0) ? CW'(1) :
                    ((half_ext > half_lim) ? half_lim : half_ext);
  assign seg_end  = (div_plus >= eff_half);
  assign bc_inc   = bit_count + 4'd1;
  assign shift_wr = {shift_reg[6:0], 1'b0};
  assign shift_rd = {shift_reg[6:0], sda_in};

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    divider_next     = divider;
    shift_reg_next   = shift_reg;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    ack_sampled_next = ack_sampled;
    ack_to_send_next = ack_to_send;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    case (phase)
      i2cme_pkg::PH_IDLE: begin
        if (cmd_valid) begin
          divider_next   = '0;
          bit_count_next = '0;
          case (action)
            i2cme_pkg::ACT_START: begin
              phase_next     = i2cme_pkg::PH_START;
              sda_level_next = 1'b0;
            end
            i2cme_pkg::ACT_STOP: begin
              phase_next     = i2cme_pkg::PH_STOP;
              scl_level_next = 1'b0;
              sda_level_next = 1'b0;
            end
            i2cme_pkg::ACT_WRITE: begin
              phase_next     = i2cme_pkg::PH_WR_LOW;
              shift_reg_next = tx_byte;
              scl_level_next = 1'b0;
              sda_level_next = tx_byte[7];
            end
            default: begin
              phase_next       = i2cme_pkg::PH_RD_LOW;
              shift_reg_next   = '0;
              ack_to_send_next = send_ack;
              scl_level_next   = 1'b0;
              sda_level_next   = 1'b1;
            end
          endcase
        end
      end
      i2cme_pkg::PH_START,
      i2cme_pkg::PH_STOP,
      i2cme_pkg::PH_WR_LOW,
      i2cme_pkg::PH_WR_HIGH,
      i2cme_pkg::PH_RD_LOW,
      i2cme_pkg::PH_RD_HIGH: begin
        if (!seg_end) begin
          divider_next = divider + DIVIDER_BITS'(1);
        end else begin
          divider_next = '0;
          case (phase)
            i2cme_pkg::PH_START: begin
              phase_next = i2cme_pkg::PH_IDLE;
              done       = 1'b1;
            end
            i2cme_pkg::PH_STOP: begin
              if (bit_count == i2cme_pkg::STOP_SCL_STEP) begin
                scl_level_next = 1'b1;
                bit_count_next = bc_inc;
              end else if (bit_count == i2cme_pkg::STOP_SDA_STEP) begin
                sda_level_next = 1'b1;
                bit_count_next = bc_inc;
              end else begin
                phase_next = i2cme_pkg::PH_IDLE;
                done       = 1'b1;
              end
            end
            i2cme_pkg::PH_WR_LOW: begin
              phase_next     = i2cme_pkg::PH_WR_HIGH;
              scl_level_next = 1'b1;
            end
            i2cme_pkg::PH_WR_HIGH: begin
              if (bit_count >= i2cme_pkg::BYTE_BITS) begin
                ack_sampled_next = sda_in;
                phase_next       = i2cme_pkg::PH_IDLE;
                done             = 1'b1;
              end else begin
                shift_reg_next = shift_wr;
                bit_count_next = bc_inc;
                phase_next     = i2cme_pkg::PH_WR_LOW;
                scl_level_next = 1'b0;
                sda_level_next = (bc_inc < i2cme_pkg::BYTE_BITS) ? shift_wr[7] : 1'b1;
              end
            end
            i2cme_pkg::PH_RD_LOW: begin
              phase_next     = i2cme_pkg::PH_RD_HIGH;
              scl_level_next = 1'b1;
            end
            default: begin
              if (bit_count >= i2cme_pkg::BYTE_BITS) begin
                phase_next = i2cme_pkg::PH_IDLE;
                done       = 1'b1;
              end else begin
                shift_reg_next = shift_rd;
                if (bit_count == i2cme_pkg::LAST_DATA_BIT) begin
                  rx_hold_next = shift_rd;
                end
                bit_count_next = bc_inc;
                phase_next     = i2cme_pkg::PH_RD_LOW;
                scl_level_next = 1'b0;
                sda_level_next = (bc_inc < i2cme_pkg::BYTE_BITS) ? 1'b1 : !ack_to_send;
              end
            end
          endcase
        end
      end
      default: begin
        phase_next = i2cme_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cme_pkg::HALF_PERIOD_RESET;
      phase       <= i2cme_pkg::PH_IDLE;
      bit_count   <= '0;
      divider     <= '0;
      shift_reg   <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      ack_sampled <= 1'b0;
      ack_to_send <= 1'b0;
      rx_hold     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period <= cfg_data;
      end
      if (beat) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        divider     <= divider_next;
        shift_reg   <= shift_reg_next;
        scl_level   <= scl_level_next;
        sda_level   <= sda_level_next;
        ack_sampled <= ack_sampled_next;
        ack_to_send <= ack_to_send_next;
        rx_hold     <= rx_hold_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (beat) begin
      m_tdata <= {3'b000, ack_sampled_next, rx_hold_next, done,
                  (phase_next == i2cme_pkg::PH_IDLE), sda_level_next, scl_level_next};
    end
  end

endmodule
`default_nettype wire

### sv/i2cme_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cme_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // no result beat pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // every accepted tick gives a result beat in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat without result");

  // input side is open whenever the output register is empty
  a_open: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a finishing command leaves the engine ready
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2])
    else $error("done without ready");

endmodule

bind i2c_master_byte_engine i2cme_checker u_i2cme_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
